/* design/krts_pkg.sv */
// Shared types, constants and helpers for the keyed record table sorter.
// Depends on nothing; used by krts_store and keyed_record_table_sorter.
package krts_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	// command codes
	localparam logic [4:0] CMD_TAIL        = 5'd0;
	localparam logic [4:0] CMD_HEAD        = 5'd1;
	localparam logic [4:0] CMD_DEL_HEAD    = 5'd2;
	localparam logic [4:0] CMD_DEL_CODE    = 5'd3;
	localparam logic [4:0] CMD_FIND        = 5'd4;
	localparam logic [4:0] CMD_UPDATE      = 5'd5;
	localparam logic [4:0] CMD_COUNT       = 5'd6;
	localparam logic [4:0] CMD_SORT_PA     = 5'd7;
	localparam logic [4:0] CMD_SORT_PD     = 5'd8;
	localparam logic [4:0] CMD_SORT_RA     = 5'd9;
	localparam logic [4:0] CMD_SORT_RD     = 5'd10;
	localparam logic [4:0] CMD_READ        = 5'd11;
	localparam logic [4:0] CMD_MAX_P       = 5'd12;
	localparam logic [4:0] CMD_MIN_P       = 5'd13;
	localparam logic [4:0] CMD_MAX_R       = 5'd14;
	localparam logic [4:0] CMD_MIN_R       = 5'd15;
	localparam logic [4:0] CMD_FIND_RIDERS = 5'd16;
	localparam logic [4:0] CMD_FIND_PRICE  = 5'd17;

	// status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_MISS  = 3'd1;
	localparam logic [2:0] ST_DUP   = 3'd2;
	localparam logic [2:0] ST_FULL  = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;

	typedef struct packed {
		logic [23:0] code;
		logic [63:0] tag;
		logic [30:0] price;
		logic [15:0] riders;
	} rec_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] slot;
		rec_t       rec;
		logic       last;
	} res_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_READ_RD,
		S_READ_CHK,
		S_SORT_RDI,
		S_SORT_LDI,
		S_SORT_RDJ,
		S_SORT_CMP,
		S_SORT_WRI,
		S_EXT_RD,
		S_EXT_CHK,
		S_EMIT_RD,
		S_EMIT_CHK,
		S_RESP
	} state_t;

	// fold lower-case letters to upper case in each of the three bytes
	function automatic logic [23:0] fold(input logic [23:0] c);
		logic [23:0] r;
		logic [7:0]  b;
		r = '0;
		for (int i = 0; i < 3; i++) begin
			b = c[8*i +: 8];
			if (b >= 8'h61 && b <= 8'h7A)
				b = b - 8'h20;
			r[8*i +: 8] = b;
		end
		return r;
	endfunction

	// physical slot of a list position
	function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
			input logic [CNT_W-1:0] p);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(h) + (CNT_W+1)'(p);
		if (s >= (CNT_W+1)'(ENTRIES))
			s = s - (CNT_W+1)'(ENTRIES);
		return s[IDX_W-1:0];
	endfunction

	function automatic logic [30:0] key_of(input rec_t r, input logic by_r);
		return by_r ? 31'(r.riders) : r.price;
	endfunction

endpackage

/* design/krts_store.sv */
// Record store: one write port, one read port with registered read data.
// Depends on krts_pkg for the record type and depth.
module krts_store (
	input  logic                        clk,
	input  logic                        we,
	input  logic [krts_pkg::IDX_W-1:0]  waddr,
	input  krts_pkg::rec_t              wdata,
	input  logic [krts_pkg::IDX_W-1:0]  raddr,
	output krts_pkg::rec_t              rdata
);

	krts_pkg::rec_t mem [krts_pkg::ENTRIES];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

/* design/keyed_record_table_sorter.sv */
// Keyed record table sorter: ordered table of up to ENTRIES records in a circular store.
// Finds, updates and extremes scan the table one entry at a time (extremes scan it twice), a middle
// delete moves each later entry one place toward the head, and a sort is an exchange sort over pairs;
// one command at a time, one store port each way.
// Reset clears the sequencer, head and fill count; the table comes up empty with no sweep.
// Depends on krts_pkg and krts_store.
module keyed_record_table_sorter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  cmd,
	input  logic [23:0] record_code,
	input  logic [63:0] name_tag,
	input  logic [30:0] price_in,
	input  logic [15:0] riders_in,
	input  logic [3:0]  slot_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [3:0]  slot_out,
	output logic [23:0] code_out,
	output logic [63:0] tag_out,
	output logic [30:0] price_out,
	output logic [15:0] riders_out,
	output logic [4:0]  fill_out,
	output logic        last
);

	localparam int IDX_W = krts_pkg::IDX_W;
	localparam int CNT_W = krts_pkg::CNT_W;

	krts_pkg::state_t state_q, state_d, ret_q, ret_d;
	logic [4:0]       cmd_q, cmd_d;
	krts_pkg::rec_t   in_q, in_d;
	logic [IDX_W-1:0] head_q, head_d;
	logic [CNT_W-1:0] fill_q, fill_d;
	logic [CNT_W-1:0] pos_q, pos_d;
	logic [CNT_W-1:0] j_q, j_d;
	krts_pkg::rec_t   a_q, a_d;
	logic [30:0]      ext_q, ext_d;
	krts_pkg::rec_t   pend_q, pend_d;
	logic [3:0]       pend_slot_q, pend_slot_d;
	logic             have_q, have_d;
	krts_pkg::res_t   res_q, res_d;

	// store port
	logic             we;
	logic [IDX_W-1:0] waddr, raddr;
	krts_pkg::rec_t   wdata, rd;

	// output register
	logic             out_valid_q;
	krts_pkg::res_t   out_q;
	logic [4:0]       out_fill_q;
	logic             out_load;

	logic             out_free;
	logic             by_r, desc, want_max, hit, better, swap;
	logic [30:0]      kv;
	krts_pkg::rec_t   upd;
	krts_pkg::rec_t   in_rec;

	krts_store u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd)
	);

	assign in_rec = '{code: record_code, tag: name_tag, price: price_in, riders: riders_in};
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != krts_pkg::S_IDLE);

	// key selection, direction of sorts and extremes
	assign by_r     = (cmd_q == krts_pkg::CMD_SORT_RA) || (cmd_q == krts_pkg::CMD_SORT_RD) ||
	                  (cmd_q == krts_pkg::CMD_MAX_R) || (cmd_q == krts_pkg::CMD_MIN_R);
	assign desc     = (cmd_q == krts_pkg::CMD_SORT_PD) || (cmd_q == krts_pkg::CMD_SORT_RD);
	assign want_max = (cmd_q == krts_pkg::CMD_MAX_P) || (cmd_q == krts_pkg::CMD_MAX_R);
	assign kv       = krts_pkg::key_of(rd, by_r);
	assign better   = want_max ? (kv > ext_q) : (kv < ext_q);
	assign swap     = desc ? (krts_pkg::key_of(a_q, by_r) < kv)
	                       : (krts_pkg::key_of(a_q, by_r) > kv);

	// match test of the scan: code (case folded), count or price
	always_comb begin
		case (cmd_q)
			krts_pkg::CMD_FIND_RIDERS: hit = (rd.riders == in_q.riders);
			krts_pkg::CMD_FIND_PRICE:  hit = (rd.price == in_q.price);
			default:                   hit = (krts_pkg::fold(rd.code) ==
			                                  krts_pkg::fold(in_q.code));
		endcase
	end

	// update keeps the stored code and takes the rest from the command
	assign upd = '{code: rd.code, tag: in_q.tag, price: in_q.price, riders: in_q.riders};

	always_comb begin
		state_d     = state_q;
		ret_d       = ret_q;
		cmd_d       = cmd_q;
		in_d        = in_q;
		head_d      = head_q;
		fill_d      = fill_q;
		pos_d       = pos_q;
		j_d         = j_q;
		a_d         = a_q;
		ext_d       = ext_q;
		pend_d      = pend_q;
		pend_slot_d = pend_slot_q;
		have_d      = have_q;
		res_d       = res_q;
		we          = 1'b0;
		waddr       = krts_pkg::phys(head_q, pos_q);
		wdata       = rd;
		raddr       = krts_pkg::phys(head_q, pos_q);
		out_load    = 1'b0;

		case (state_q)
			krts_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd_d  = cmd;
					in_d   = in_rec;
					pos_d  = '0;
					have_d = 1'b0;
					ret_d  = krts_pkg::S_IDLE;
					res_d  = '{status: krts_pkg::ST_OK, slot: 4'd0, rec: '0, last: 1'b1};
					state_d = krts_pkg::S_RESP;
					case (cmd) inside
						krts_pkg::CMD_TAIL, krts_pkg::CMD_DEL_CODE, krts_pkg::CMD_FIND,
						krts_pkg::CMD_UPDATE, krts_pkg::CMD_FIND_RIDERS,
						krts_pkg::CMD_FIND_PRICE: begin
							state_d = krts_pkg::S_SCAN_RD;
						end
						krts_pkg::CMD_HEAD: begin
							if (fill_q >= CNT_W'(krts_pkg::ENTRIES)) begin
								res_d.status = krts_pkg::ST_FULL;
							end else begin
								// step the head back and write the new record there
								head_d = (head_q == '0) ? IDX_W'(krts_pkg::ENTRIES - 1)
								                        : head_q - 1'b1;
								we     = 1'b1;
								waddr  = head_d;
								wdata  = in_rec;
								fill_d = fill_q + 1'b1;
								res_d.rec = in_rec;
							end
						end
						krts_pkg::CMD_DEL_HEAD: begin
							if (fill_q == '0)
								res_d.status = krts_pkg::ST_EMPTY;
							else
								state_d = krts_pkg::S_READ_RD;
						end
						krts_pkg::CMD_READ: begin
							if (CNT_W'(slot_in) >= fill_q) begin
								res_d.status = krts_pkg::ST_MISS;
							end else begin
								pos_d   = CNT_W'(slot_in);
								state_d = krts_pkg::S_READ_RD;
							end
						end
						[krts_pkg::CMD_SORT_PA : krts_pkg::CMD_SORT_RD]: begin
							if (fill_q == '0)
								res_d.status = krts_pkg::ST_EMPTY;
							else
								state_d = krts_pkg::S_SORT_RDI;
						end
						[krts_pkg::CMD_MAX_P : krts_pkg::CMD_MIN_R]: begin
							if (fill_q == '0)
								res_d.status = krts_pkg::ST_EMPTY;
							else
								state_d = krts_pkg::S_EXT_RD;
						end
						default: ;
					endcase
				end
			end

			// linear search from the head
			krts_pkg::S_SCAN_RD: begin
				if (pos_q == fill_q) begin
					state_d = krts_pkg::S_RESP;
					res_d   = '{status: krts_pkg::ST_MISS, slot: 4'd0, rec: '0, last: 1'b1};
					if (cmd_q == krts_pkg::CMD_TAIL) begin
						if (fill_q >= CNT_W'(krts_pkg::ENTRIES)) begin
							res_d.status = krts_pkg::ST_FULL;
						end else begin
							// append at the tail
							we     = 1'b1;
							waddr  = krts_pkg::phys(head_q, fill_q);
							wdata  = in_q;
							fill_d = fill_q + 1'b1;
							res_d  = '{status: krts_pkg::ST_OK, slot: fill_q[3:0],
							           rec: in_q, last: 1'b1};
						end
					end
				end else begin
					state_d = krts_pkg::S_SCAN_CHK;
				end
			end

			krts_pkg::S_SCAN_CHK: begin
				if (hit) begin
					res_d   = '{status: krts_pkg::ST_OK, slot: pos_q[3:0], rec: rd, last: 1'b1};
					state_d = krts_pkg::S_RESP;
					case (cmd_q)
						krts_pkg::CMD_TAIL: res_d.status = krts_pkg::ST_DUP;
						krts_pkg::CMD_UPDATE: begin
							we        = 1'b1;
							wdata     = upd;
							res_d.rec = upd;
						end
						krts_pkg::CMD_DEL_CODE: begin
							if (pos_q == '0) begin
								head_d = (head_q == IDX_W'(krts_pkg::ENTRIES - 1)) ? '0
								                                                     : head_q + 1'b1;
								fill_d = fill_q - 1'b1;
							end else begin
								state_d = krts_pkg::S_SHIFT_RD;
							end
						end
						default: ;
					endcase
				end else begin
					pos_d   = pos_q + 1'b1;
					state_d = krts_pkg::S_SCAN_RD;
				end
			end

			// close the gap: move each later record one place toward the head
			krts_pkg::S_SHIFT_RD: begin
				raddr = krts_pkg::phys(head_q, pos_q + 1'b1);
				if (pos_q + 1'b1 >= fill_q) begin
					fill_d  = fill_q - 1'b1;
					state_d = krts_pkg::S_RESP;
				end else begin
					state_d = krts_pkg::S_SHIFT_WR;
				end
			end

			krts_pkg::S_SHIFT_WR: begin
				we      = 1'b1;
				pos_d   = pos_q + 1'b1;
				state_d = krts_pkg::S_SHIFT_RD;
			end

			krts_pkg::S_READ_RD: begin
				state_d = krts_pkg::S_READ_CHK;
			end

			krts_pkg::S_READ_CHK: begin
				res_d   = '{status: krts_pkg::ST_OK, slot: pos_q[3:0], rec: rd, last: 1'b1};
				state_d = krts_pkg::S_RESP;
				if (cmd_q == krts_pkg::CMD_DEL_HEAD) begin
					head_d = (head_q == IDX_W'(krts_pkg::ENTRIES - 1)) ? '0 : head_q + 1'b1;
					fill_d = fill_q - 1'b1;
				end
			end

			// exchange sort: a_q holds the record currently at position i
			krts_pkg::S_SORT_RDI: begin
				if (pos_q >= fill_q)
					state_d = krts_pkg::S_RESP;
				else
					state_d = krts_pkg::S_SORT_LDI;
			end

			krts_pkg::S_SORT_LDI: begin
				a_d     = rd;
				j_d     = pos_q + 1'b1;
				state_d = krts_pkg::S_SORT_RDJ;
			end

			krts_pkg::S_SORT_RDJ: begin
				raddr = krts_pkg::phys(head_q, j_q);
				if (j_q >= fill_q) begin
					pos_d   = pos_q + 1'b1;
					state_d = krts_pkg::S_SORT_RDI;
				end else begin
					state_d = krts_pkg::S_SORT_CMP;
				end
			end

			krts_pkg::S_SORT_CMP: begin
				j_d     = j_q + 1'b1;
				state_d = krts_pkg::S_SORT_RDJ;
				if (swap) begin
					// old i record goes to j now, new i record is written next cycle
					we      = 1'b1;
					waddr   = krts_pkg::phys(head_q, j_q);
					wdata   = a_q;
					a_d     = rd;
					state_d = krts_pkg::S_SORT_WRI;
				end
			end

			krts_pkg::S_SORT_WRI: begin
				we      = 1'b1;
				wdata   = a_q;
				state_d = krts_pkg::S_SORT_RDJ;
			end

			// first pass: find the extreme key
			krts_pkg::S_EXT_RD: begin
				state_d = krts_pkg::S_EXT_CHK;
			end

			krts_pkg::S_EXT_CHK: begin
				if (pos_q == '0 || better)
					ext_d = kv;
				if (pos_q + 1'b1 == fill_q) begin
					pos_d   = '0;
					state_d = krts_pkg::S_EMIT_RD;
				end else begin
					pos_d   = pos_q + 1'b1;
					state_d = krts_pkg::S_EXT_RD;
				end
			end

			// second pass: report matches, holding one back to mark the last
			krts_pkg::S_EMIT_RD: begin
				if (pos_q == fill_q) begin
					res_d   = '{status: krts_pkg::ST_OK, slot: pend_slot_q, rec: pend_q,
					            last: 1'b1};
					ret_d   = krts_pkg::S_IDLE;
					state_d = krts_pkg::S_RESP;
				end else begin
					state_d = krts_pkg::S_EMIT_CHK;
				end
			end

			krts_pkg::S_EMIT_CHK: begin
				pos_d   = pos_q + 1'b1;
				state_d = krts_pkg::S_EMIT_RD;
				if (kv == ext_q) begin
					pend_d      = rd;
					pend_slot_d = pos_q[3:0];
					have_d      = 1'b1;
					if (have_q) begin
						res_d   = '{status: krts_pkg::ST_OK, slot: pend_slot_q, rec: pend_q,
						            last: 1'b0};
						ret_d   = krts_pkg::S_EMIT_RD;
						state_d = krts_pkg::S_RESP;
					end
				end
			end

			// hold the result until the output register frees up
			krts_pkg::S_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ret_q;
				end
			end

			default: state_d = krts_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= krts_pkg::S_IDLE;
			ret_q       <= krts_pkg::S_IDLE;
			head_q      <= '0;
			fill_q      <= '0;
			have_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			head_q  <= head_d;
			fill_q  <= fill_d;
			have_q  <= have_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cmd_q       <= cmd_d;
		in_q        <= in_d;
		pos_q       <= pos_d;
		j_q         <= j_d;
		a_q         <= a_d;
		ext_q       <= ext_d;
		pend_q      <= pend_d;
		pend_slot_q <= pend_slot_d;
		res_q       <= res_d;
		if (out_load) begin
			out_q      <= res_q;
			out_fill_q <= 5'(fill_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_q.status;
	assign slot_out   = out_q.slot;
	assign code_out   = out_q.rec.code;
	assign tag_out    = out_q.rec.tag;
	assign price_out  = out_q.rec.price;
	assign riders_out = out_q.rec.riders;
	assign fill_out   = out_fill_q;
	assign last       = out_q.last;

endmodule

/* tb/keyed_record_table_sorter_tb.sv */
// Self-checking testbench for keyed_record_table_sorter: a directed table of commands,
// then random commands, all checked against a behavioral table model held here.
// Depends on krts_pkg and the keyed_record_table_sorter RTL.
module keyed_record_table_sorter_tb;

	// one command transaction
	typedef struct {
		logic [4:0]  cmd;
		logic [23:0] code;
		logic [63:0] tag;
		logic [30:0] price;
		logic [15:0] riders;
		logic [3:0]  slot;
		logic        chk;     // typed expectation present for this row
		logic [2:0]  x_status;
		logic [4:0]  x_fill;
	} cmd_item_t;

	// one result transaction
	typedef struct {
		logic [2:0]  status;
		logic [3:0]  slot;
		logic [23:0] code;
		logic [63:0] tag;
		logic [30:0] price;
		logic [15:0] riders;
		logic [4:0]  fill;
		logic        last;
	} table_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [4:0]  cmd = '0;
	logic [23:0] record_code = '0;
	logic [63:0] name_tag = '0;
	logic [30:0] price_in = '0;
	logic [15:0] riders_in = '0;
	logic [3:0]  slot_in = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [3:0]  slot_out;
	logic [23:0] code_out;
	logic [63:0] tag_out;
	logic [30:0] price_out;
	logic [15:0] riders_out;
	logic [4:0]  fill_out;
	logic        last;

	keyed_record_table_sorter dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow table, kept in list order (position 0 is the head)
	krts_pkg::rec_t shadow_tbl[$];
	table_result_t  pending_results[$];
	cmd_item_t      stim_q[$];
	int             mismatches = 0;
	int             idle_cycles = 0;
	bit             timed_out = 0;
	bit             hold_off = 0;   // long receiver hold-off request
	bit             drain_req = 0;  // sender pause until all results are in
	bit             stim_done = 0;

	localparam int WATCHDOG = 20000;

	function automatic logic [23:0] upcase(input logic [23:0] c);
		logic [23:0] r;
		logic [7:0]  b;
		for (int i = 0; i < 3; i++) begin
			b = c[8*i +: 8];
			if (b >= "a" && b <= "z")
				b = b - 8'h20;
			r[8*i +: 8] = b;
		end
		return r;
	endfunction

	function automatic int locate_code(input logic [23:0] c);
		for (int i = 0; i < shadow_tbl.size(); i++)
			if (upcase(shadow_tbl[i].code) == upcase(c))
				return i;
		return -1;
	endfunction

	function automatic logic [30:0] sort_key(input krts_pkg::rec_t r, input bit by_r);
		return by_r ? {15'd0, r.riders} : r.price;
	endfunction

	function automatic table_result_t blank_result(input logic [2:0] st);
		table_result_t t;
		t = '{status: st, slot: '0, code: '0, tag: '0, price: '0, riders: '0,
			fill: 5'(shadow_tbl.size()), last: 1'b0};
		return t;
	endfunction

	function automatic table_result_t record_result(input logic [2:0] st, input int pos);
		table_result_t t;
		t = blank_result(st);
		t.slot = 4'(pos);
		t.code = shadow_tbl[pos].code;
		t.tag = shadow_tbl[pos].tag;
		t.price = shadow_tbl[pos].price;
		t.riders = shadow_tbl[pos].riders;
		return t;
	endfunction

	// apply one command to the shadow table and queue its expected results
	task automatic predict_table_op(input cmd_item_t it);
		table_result_t  outs[$];
		table_result_t  t;
		krts_pkg::rec_t nr, tmp;
		int             f, n;
		bit             by_r, desc, want_max;
		logic [30:0]    ext, a, b;
		nr = '{code: it.code, tag: it.tag, price: it.price, riders: it.riders};
		case (it.cmd)
			krts_pkg::CMD_TAIL: begin
				f = locate_code(it.code);
				if (f >= 0)
					outs.push_back(record_result(krts_pkg::ST_DUP, f));
				else if (shadow_tbl.size() >= krts_pkg::ENTRIES)
					outs.push_back(blank_result(krts_pkg::ST_FULL));
				else begin
					shadow_tbl.push_back(nr);
					outs.push_back(record_result(krts_pkg::ST_OK, shadow_tbl.size() - 1));
				end
			end
			krts_pkg::CMD_HEAD: begin
				if (shadow_tbl.size() >= krts_pkg::ENTRIES)
					outs.push_back(blank_result(krts_pkg::ST_FULL));
				else begin
					shadow_tbl.push_front(nr);
					outs.push_back(record_result(krts_pkg::ST_OK, 0));
				end
			end
			krts_pkg::CMD_DEL_HEAD, krts_pkg::CMD_DEL_CODE: begin
				if (it.cmd == krts_pkg::CMD_DEL_HEAD)
					f = shadow_tbl.size() ? 0 : -1;
				else
					f = locate_code(it.code);
				if (f < 0)
					outs.push_back(blank_result(it.cmd == krts_pkg::CMD_DEL_HEAD ?
						krts_pkg::ST_EMPTY : krts_pkg::ST_MISS));
				else begin
					t = record_result(krts_pkg::ST_OK, f);
					shadow_tbl.delete(f);
					t.fill = 5'(shadow_tbl.size());
					outs.push_back(t);
				end
			end
			krts_pkg::CMD_FIND, krts_pkg::CMD_UPDATE: begin
				f = locate_code(it.code);
				if (f < 0)
					outs.push_back(blank_result(krts_pkg::ST_MISS));
				else begin
					if (it.cmd == krts_pkg::CMD_UPDATE) begin
						shadow_tbl[f].tag = it.tag;
						shadow_tbl[f].price = it.price;
						shadow_tbl[f].riders = it.riders;
					end
					outs.push_back(record_result(krts_pkg::ST_OK, f));
				end
			end
			krts_pkg::CMD_SORT_PA, krts_pkg::CMD_SORT_PD, krts_pkg::CMD_SORT_RA,
			krts_pkg::CMD_SORT_RD: begin
				if (shadow_tbl.size() == 0)
					outs.push_back(blank_result(krts_pkg::ST_EMPTY));
				else begin
					by_r = (it.cmd == krts_pkg::CMD_SORT_RA || it.cmd == krts_pkg::CMD_SORT_RD);
					desc = (it.cmd == krts_pkg::CMD_SORT_PD || it.cmd == krts_pkg::CMD_SORT_RD);
					for (int i = 0; i < shadow_tbl.size(); i++)
						for (int j = i + 1; j < shadow_tbl.size(); j++) begin
							a = sort_key(shadow_tbl[i], by_r);
							b = sort_key(shadow_tbl[j], by_r);
							if (desc ? (a < b) : (a > b)) begin
								tmp = shadow_tbl[i];
								shadow_tbl[i] = shadow_tbl[j];
								shadow_tbl[j] = tmp;
							end
						end
					outs.push_back(blank_result(krts_pkg::ST_OK));
				end
			end
			krts_pkg::CMD_READ: begin
				if (it.slot >= shadow_tbl.size())
					outs.push_back(blank_result(krts_pkg::ST_MISS));
				else
					outs.push_back(record_result(krts_pkg::ST_OK, it.slot));
			end
			krts_pkg::CMD_MAX_P, krts_pkg::CMD_MIN_P, krts_pkg::CMD_MAX_R,
			krts_pkg::CMD_MIN_R: begin
				if (shadow_tbl.size() == 0)
					outs.push_back(blank_result(krts_pkg::ST_EMPTY));
				else begin
					by_r = (it.cmd == krts_pkg::CMD_MAX_R || it.cmd == krts_pkg::CMD_MIN_R);
					want_max = (it.cmd == krts_pkg::CMD_MAX_P || it.cmd == krts_pkg::CMD_MAX_R);
					ext = sort_key(shadow_tbl[0], by_r);
					foreach (shadow_tbl[i])
						if (want_max ? (sort_key(shadow_tbl[i], by_r) > ext)
								: (sort_key(shadow_tbl[i], by_r) < ext))
							ext = sort_key(shadow_tbl[i], by_r);
					n = 0;
					foreach (shadow_tbl[i])
						if (n < 16 && sort_key(shadow_tbl[i], by_r) == ext) begin
							outs.push_back(record_result(krts_pkg::ST_OK, i));
							n++;
						end
				end
			end
			krts_pkg::CMD_FIND_RIDERS, krts_pkg::CMD_FIND_PRICE: begin
				f = -1;
				foreach (shadow_tbl[i])
					if (f < 0 && ((it.cmd == krts_pkg::CMD_FIND_RIDERS) ?
							(shadow_tbl[i].riders == it.riders) :
							(shadow_tbl[i].price == it.price)))
						f = i;
				outs.push_back(f < 0 ? blank_result(krts_pkg::ST_MISS)
					: record_result(krts_pkg::ST_OK, f));
			end
			default: outs.push_back(blank_result(krts_pkg::ST_OK));
		endcase
		outs[$].last = 1'b1;
		// a typed-in row must agree with the model on status and fill
		if (it.chk && (outs[0].status !== it.x_status || outs[0].fill !== it.x_fill)) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table row cmd %0d: expected status %0d fill %0d, model %0d %0d",
					it.cmd, it.x_status, it.x_fill, outs[0].status, outs[0].fill);
		end
		foreach (outs[i])
			pending_results.push_back(outs[i]);
	endtask

	function automatic cmd_item_t mk(input logic [4:0] c, input logic [23:0] code,
			input logic [63:0] tg, input logic [30:0] p, input logic [15:0] r,
			input logic [3:0] s, input logic ck, input logic [2:0] xs, input logic [4:0] xf);
		cmd_item_t it;
		it = '{cmd: c, code: code, tag: tg, price: p, riders: r, slot: s,
			chk: ck, x_status: xs, x_fill: xf};
		return it;
	endfunction

	// draw a code from a small alphabet so duplicates and case folding hit often
	function automatic logic [23:0] rand_code();
		logic [23:0] c;
		if ($urandom_range(0, 9) == 0)
			return 24'($urandom);
		c = {"A", "A", 8'("A" + $urandom_range(0, 5))};
		if ($urandom_range(0, 1))
			c[7:0] = c[7:0] + 8'h20;
		if ($urandom_range(0, 3) == 0)
			c[23:16] = "a";
		return c;
	endfunction

	function automatic cmd_item_t rand_item(input int fill_hint);
		cmd_item_t it;
		int        w;
		it = mk(krts_pkg::CMD_TAIL, rand_code(), {$urandom, $urandom},
			31'($urandom_range(0, 7)), 16'($urandom_range(0, 7)), 4'($urandom), 1'b0,
			krts_pkg::ST_OK, '0);
		if ($urandom_range(0, 4) == 0) begin
			it.price = 31'($urandom);
			it.riders = 16'($urandom);
		end
		w = $urandom_range(0, 99);
		// lean toward inserts while the table is small, deletes when it is large
		if (w < (fill_hint < 8 ? 45 : 20))
			it.cmd = $urandom_range(0, 3) ? krts_pkg::CMD_TAIL : krts_pkg::CMD_HEAD;
		else if (w < 55)
			it.cmd = $urandom_range(0, 1) ? krts_pkg::CMD_DEL_HEAD : krts_pkg::CMD_DEL_CODE;
		else if (w < 97)
			it.cmd = 5'($urandom_range(krts_pkg::CMD_FIND, krts_pkg::CMD_FIND_PRICE));
		else
			it.cmd = 5'($urandom_range(krts_pkg::CMD_FIND_PRICE + 1, 31));
		return it;
	endfunction

	// stimulus: drive one transaction per accept, bursts with random gaps
	initial begin
		cmd_item_t it;
		int        burst, fill_est;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed table: empty-table cases, extremes of fields, full table, every command
		stim_q.push_back(mk(krts_pkg::CMD_DEL_HEAD, "ABC", '0, '0, '0, '0, 1,
			krts_pkg::ST_EMPTY, 5'd0));
		stim_q.push_back(mk(krts_pkg::CMD_SORT_PA, '0, '0, '0, '0, '0, 1,
			krts_pkg::ST_EMPTY, 5'd0));
		stim_q.push_back(mk(krts_pkg::CMD_MAX_P, '0, '0, '0, '0, '0, 1,
			krts_pkg::ST_EMPTY, 5'd0));
		stim_q.push_back(mk(krts_pkg::CMD_FIND, "ABC", '0, '0, '0, '0, 1,
			krts_pkg::ST_MISS, 5'd0));
		stim_q.push_back(mk(krts_pkg::CMD_READ, '0, '0, '0, '0, 4'hF, 1,
			krts_pkg::ST_MISS, 5'd0));
		stim_q.push_back(mk(krts_pkg::CMD_TAIL, 24'hFFFFFF, '1, '1, '1, '0, 1,
			krts_pkg::ST_OK, 5'd1));
		stim_q.push_back(mk(krts_pkg::CMD_TAIL, "abc", '0, '0, '0, '0, 1,
			krts_pkg::ST_OK, 5'd2));
		stim_q.push_back(mk(krts_pkg::CMD_TAIL, "ABC", 64'h5, 31'd9, 16'd9, '0, 1,
			krts_pkg::ST_DUP, 5'd2));
		stim_q.push_back(mk(krts_pkg::CMD_HEAD, "abc", 64'h7, 31'd5, 16'd5, '0, 1,
			krts_pkg::ST_OK, 5'd3));
		for (int i = 0; i < 13; i++)
			stim_q.push_back(mk(krts_pkg::CMD_TAIL, {"Q", "Z", 8'("a" + i)}, 64'(i),
				31'(i % 3), 16'(i % 4), '0, 1'b0, krts_pkg::ST_OK, '0));
		stim_q.push_back(mk(krts_pkg::CMD_HEAD, "XYZ", '0, '0, '0, '0, 1,
			krts_pkg::ST_FULL, 5'd16));
		stim_q.push_back(mk(krts_pkg::CMD_TAIL, "XYZ", '0, '0, '0, '0, 1,
			krts_pkg::ST_FULL, 5'd16));
		for (int c = krts_pkg::CMD_FIND; c <= krts_pkg::CMD_FIND_PRICE + 1; c++)
			stim_q.push_back(mk(5'(c), "QZc", 64'hAA, 31'd1, 16'd2, 4'(c), 1'b0,
				krts_pkg::ST_OK, '0));
		stim_q.push_back(mk(krts_pkg::CMD_DEL_CODE, "qzb", '0, '0, '0, '0, 1'b0,
			krts_pkg::ST_OK, '0));
		foreach (stim_q[i]) begin
			predict_table_op(stim_q[i]);
			in_valid <= 1'b1;
			{cmd, record_code, name_tag, price_in, riders_in, slot_in} <=
				{stim_q[i].cmd, stim_q[i].code, stim_q[i].tag, stim_q[i].price,
				stim_q[i].riders, stim_q[i].slot};
			@(posedge clk);
			while (in_stall) @(posedge clk);
			if ($urandom_range(0, 2) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
		end
		// random part; one long receiver hold-off and one full drain along the way
		for (int k = 0; k < 140; k++) begin
			if (k == 40)
				hold_off = 1;
			if (k == 100) begin
				in_valid <= 1'b0;
				drain_req = 1;
				@(posedge clk);
				while (pending_results.size() != 0 && !timed_out) @(posedge clk);
				drain_req = 0;
			end
			burst = $urandom_range(1, 8);
			fill_est = shadow_tbl.size();
			it = rand_item(fill_est);
			predict_table_op(it);
			in_valid <= 1'b1;
			{cmd, record_code, name_tag, price_in, riders_in, slot_in} <=
				{it.cmd, it.code, it.tag, it.price, it.riders, it.slot};
			@(posedge clk);
			while (in_stall) @(posedge clk);
			if (burst < 3) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
		stim_done = 1;
	end

	// receiver: stall on its own pattern, including one long hold-off
	initial begin
		int phase;
		phase = 0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_off = 0;
				out_stall <= 1'b0;
			end else begin
				phase++;
				// alternate stretches of clean flow with stretches of random stalls
				if ((phase / 64) % 2)
					out_stall <= ($urandom_range(0, 3) == 0);
				else
					out_stall <= 1'b0;
			end
		end
	end

	// compare every accepted result with the oldest expectation
	always @(posedge clk) begin
		table_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d code %h", status, code_out);
			end else begin
				want = pending_results.pop_front();
				if (want.status !== status || want.slot !== slot_out ||
						want.code !== code_out || want.tag !== tag_out ||
						want.price !== price_out || want.riders !== riders_out ||
						want.fill !== fill_out || want.last !== last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result mismatch: expected st %0d pos %0d code %h tag %h",
							" price %0d riders %0d fill %0d last %0d; got %0d %0d %h %h",
							" %0d %0d %0d %0d"},
							want.status, want.slot, want.code, want.tag, want.price,
							want.riders, want.fill, want.last, status, slot_out, code_out,
							tag_out, price_out, riders_out, fill_out, last);
				end
			end
		end
	end

	// watchdog: count cycles with no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG)
			timed_out = 1;
	end

	// end of run: drain, let the block settle, then report
	initial begin
		wait (stim_done || timed_out);
		while (pending_results.size() != 0 && !timed_out) @(posedge clk);
		repeat (300) @(posedge clk);
		if (timed_out) begin
			$display("keyed_record_table_sorter regression: fail");
		end else if (mismatches == 0 && pending_results.size() == 0) begin
			$display("keyed_record_table_sorter regression: pass");
		end else begin
			$display("keyed_record_table_sorter regression: fail");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/krts_pkg.sv
design/krts_store.sv
design/keyed_record_table_sorter.sv
tb/keyed_record_table_sorter_tb.sv
